FILE: hw/rtl/sha224_256_hash_core_assert.svh
// Assertion macros for the SHA-224/256 hash core RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef SHA224_256_HASH_CORE_ASSERT_SVH
`define SHA224_256_HASH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define SHA2_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define SHA2_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA2_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SHA2_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/sha2_pkg.sv
// Shared types, constants and functions of the SHA-224/256 hash core.
// Depends on nothing.
package sha2_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int QueueCntW  = 3;

    typedef struct packed {
        logic        final_blk;
        logic [31:0] word;
    } queue_entry_t;

    typedef struct packed {
        logic we;
        logic mode;
        logic msg_open;
    } cfg_ctl_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MARK,
        F_ZERO,
        F_LEN_HI,
        F_LEN_LO
    } front_state_t;

    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_OUT
    } back_state_t;

    localparam logic [31:0] PadMark = 32'h8000_0000;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_value(input logic mode, input logic [2:0] i);
        logic [31:0] h;
        begin
            case ({mode, i})
                4'd0:  h = 32'h6a09e667; 4'd1:  h = 32'hbb67ae85;
                4'd2:  h = 32'h3c6ef372; 4'd3:  h = 32'ha54ff53a;
                4'd4:  h = 32'h510e527f; 4'd5:  h = 32'h9b05688c;
                4'd6:  h = 32'h1f83d9ab; 4'd7:  h = 32'h5be0cd19;
                4'd8:  h = 32'hc1059ed8; 4'd9:  h = 32'h367cd507;
                4'd10: h = 32'h3070dd17; 4'd11: h = 32'hf70e5939;
                4'd12: h = 32'hffc00b31; 4'd13: h = 32'h68581511;
                4'd14: h = 32'h64f98fa7; 4'd15: h = 32'hbefa4fa4;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hw/rtl/sha2_front.sv
// Front end: accepts message words, counts length and generates padding words.
// Depends on sha2_pkg.
module sha2_front
    import sha2_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [31:0]  data_word,
    input  logic [2:0]   valid_bytes,
    input  logic         last_word,
    input  logic         queue_full,
    output logic         busy,
    output logic         push,
    output queue_entry_t push_entry,
    output logic         msg_open
);

    front_state_t state_reg, state_next;
    logic [3:0]   fill_reg, fill_next;
    logic [60:0]  bytes_reg, bytes_next;
    logic [63:0]  len_reg, len_next;
    logic         open_reg, open_next;
    logic         accept;
    logic [2:0]   nb;
    logic [31:0]  tail_word;
    logic [60:0]  total_bytes;

    assign busy     = (state_reg != F_IDLE) || queue_full;
    assign accept   = start && !busy;
    assign msg_open = open_reg;

    // Clamp the byte count and build the marked partial word
    always_comb
    begin
        nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        total_bytes = bytes_reg + {58'd0, nb};
        case (nb)
            3'd0:    tail_word = PadMark;
            3'd1:    tail_word = {data_word[31:24], 8'h80, 16'h0};
            3'd2:    tail_word = {data_word[31:16], 8'h80, 8'h0};
            3'd3:    tail_word = {data_word[31:8], 8'h80};
            default: tail_word = data_word;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bytes_next = bytes_reg;
        len_next   = len_reg;
        open_next  = open_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    open_next = 1'b1;
                    fill_next = fill_reg + 4'd1;
                    if (!last_word)
                        bytes_next = bytes_reg + 61'd4;
                    else
                    begin
                        bytes_next = '0;
                        len_next   = {total_bytes, 3'b000};
                        if (nb == 3'd4)
                            state_next = F_MARK;
                        else if (fill_next == 4'd14)
                            state_next = F_LEN_HI;
                        else
                            state_next = F_ZERO;
                    end
                end
            end
            F_MARK, F_ZERO:
            begin
                if (!queue_full)
                begin
                    fill_next  = fill_reg + 4'd1;
                    state_next = (fill_next == 4'd14) ? F_LEN_HI : F_ZERO;
                end
            end
            F_LEN_HI:
            begin
                if (!queue_full)
                begin
                    fill_next  = fill_reg + 4'd1;
                    state_next = F_LEN_LO;
                end
            end
            F_LEN_LO:
            begin
                if (!queue_full)
                begin
                    fill_next  = '0;
                    open_next  = 1'b0;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs toward the queue
    always_comb
    begin
        push       = 1'b0;
        push_entry = '0;
        case (state_reg)
            F_IDLE:
            begin
                push            = accept;
                push_entry.word = last_word ? tail_word : data_word;
            end
            F_MARK:
            begin
                push            = !queue_full;
                push_entry.word = PadMark;
            end
            F_ZERO:
            begin
                push = !queue_full;
            end
            F_LEN_HI:
            begin
                push            = !queue_full;
                push_entry.word = len_reg[63:32];
            end
            F_LEN_LO:
            begin
                push                 = !queue_full;
                push_entry.word      = len_reg[31:0];
                push_entry.final_blk = 1'b1;
            end
            default: push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fill_reg  <= '0;
            bytes_reg <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bytes_reg <= bytes_next;
            open_reg  <= open_next;
        end
    end

    // Length payload needs no reset
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

FILE: hw/rtl/sha2_queue.sv
// Short word queue between the front end and the compression back end.
// Depends on sha2_pkg.
module sha2_queue
    import sha2_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output queue_entry_t head
);

    queue_entry_t              slot_reg [QueueDepth];
    logic [QueuePtrW-1:0]      wr_reg, rd_reg;
    logic [QueueCntW-1:0]      cnt_reg;

    assign full      = (cnt_reg == QueueCntW'(QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

endmodule

FILE: hw/rtl/sha2_back.sv
// Back end: block buffer, 64-round compression, chaining hash, digest output.
// Depends on sha2_pkg and the assertion macro header.
`include "sha224_256_hash_core_assert.svh"
module sha2_back
    import sha2_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         not_empty,
    input  queue_entry_t head,
    input  cfg_ctl_t     cfg,
    output logic         pop,
    output logic         result_valid,
    output logic [31:0]  digest_word,
    output logic [2:0]   word_index,
    output logic         last_result
);

    back_state_t state_reg, state_next;
    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] bw_reg [16];
    logic [3:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        final_reg;
    logic        valid_reg, last_reg;
    logic [31:0] dword_reg;
    logic [2:0]  windex_reg;
    logic [31:0] wt, s0, s1, big0, big1, ch, maj, t1, t2;
    logic        out_last;

    assign out_last = (idx_reg == (cfg.mode ? 3'd6 : 3'd7));

    // Schedule word and round function
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        if (round_reg < 6'd16)
            wt = bw_reg[round_reg[3:0]];
        else
            wt = w_reg[0] + s0 + w_reg[9] + s1;
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + round_k(round_reg) + wt;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_LOAD:  if (not_empty && fill_reg == 4'd15) state_next = B_ROUND;
            B_ROUND: if (round_reg == 6'd63) state_next = B_ADD;
            B_ADD:   state_next = final_reg ? B_OUT : B_LOAD;
            B_OUT:   if (out_last) state_next = B_LOAD;
            default: state_next = B_LOAD;
        endcase
    end

    // Outputs
    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            B_LOAD:  pop = not_empty;
            default: pop = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            fill_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= init_value(1'b0, 3'(i));
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == B_OUT);
            last_reg  <= (state_reg == B_OUT) && out_last;
            case (state_reg)
                B_LOAD:
                begin
                    round_reg <= '0;
                    idx_reg   <= '0;
                    if (pop)
                    begin
                        fill_reg  <= fill_reg + 4'd1;
                        final_reg <= head.final_blk;
                    end
                    if (cfg.we && !cfg.msg_open)
                        for (int i = 0; i < 8; i++)
                            chain_reg[i] <= init_value(cfg.mode, 3'(i));
                end
                B_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                B_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
                B_OUT:
                begin
                    idx_reg <= idx_reg + 3'd1;
                    if (out_last)
                        for (int i = 0; i < 8; i++)
                            chain_reg[i] <= init_value(cfg.mode, 3'(i));
                end
                default: round_reg <= '0;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dword_reg  <= chain_reg[idx_reg];
        windex_reg <= idx_reg;
        if (state_reg == B_LOAD)
        begin
            if (pop)
                bw_reg[fill_reg] <= head.word;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain_reg[i];
        end
        if (state_reg == B_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign result_valid = valid_reg;
    assign digest_word  = dword_reg;
    assign word_index   = windex_reg;
    assign last_result  = last_reg;

    `SHA2_ASSERT_IMP(a_pop_only_load, clk, rst_n, pop, state_reg == B_LOAD)
    `SHA2_ASSERT_NXT(a_last_ends_burst, clk, rst_n, result_valid && last_result, !result_valid)
    `SHA2_ASSERT_IMP(a_add_after_rounds, clk, rst_n, state_reg == B_ADD, round_reg == 6'd0 && $past(round_reg) == 6'd63)
    `SHA2_ASSERT_NXT(a_result_from_out, clk, rst_n, state_reg != B_OUT, !result_valid)

endmodule

FILE: hw/rtl/sha224_256_hash_core.sv
// SHA-224/256 hash core top level: mode register, front end, queue, back end.
// Depends on sha2_pkg, sha2_front, sha2_queue and sha2_back.
//
// Usage: present a message word on data_word/valid_bytes/last_word with
// start high; it is taken at a rising edge where busy is low. Bytes are
// big-endian; valid_bytes matters only on the word with last_word set.
// Write digest_mode through digest_mode_we while idle: 0 = SHA-256,
// 1 = SHA-224. With no message open a write reloads the initial hash.
// Digest words leave one per cycle, marked by result_valid, word 0 first,
// last_result on word 7 (SHA-256) or word 6 (SHA-224); the receiver cannot
// stall them. Each 16-word block is loaded, run through 64 rounds, added
// to the chain hash in the single round unit; ordinary words are taken
// every cycle while the 4-entry word queue has room. After the last word,
// padding adds one or two blocks; digest words follow the final add via
// the output state and its register. Reset clears all control state,
// selects SHA-256 and loads its initial hash; no clearing pass is needed.
module sha224_256_hash_core
    import sha2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    input  logic        digest_mode_we,
    input  logic        digest_mode,
    output logic        result_valid,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_result
);

    logic         mode_reg;
    logic         push, pop, full, not_empty, msg_open;
    queue_entry_t push_entry, head;
    cfg_ctl_t     cfg;

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (digest_mode_we)
            mode_reg <= digest_mode;
    end

    always_comb
    begin
        cfg.we       = digest_mode_we;
        cfg.mode     = digest_mode_we ? digest_mode : mode_reg;
        cfg.msg_open = msg_open;
    end

    sha2_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .data_word  (data_word),
        .valid_bytes(valid_bytes),
        .last_word  (last_word),
        .queue_full (full),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry),
        .msg_open   (msg_open)
    );

    sha2_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    sha2_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (not_empty),
        .head        (head),
        .cfg         (cfg),
        .pop         (pop),
        .result_valid(result_valid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_result (last_result)
    );

endmodule
